>>> src/pvc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvc_pkg: shared types and constants of the prefix varint codec
// Result kinds, the status structs passed from the decoder and encoder to the
// top level, and the field widths of the channels.
// ----------------------------------------------------------------------------
package pvc_pkg;

	// Field widths of the two channels.
	localparam int unsigned ByteW  = 8;
	localparam int unsigned WordW  = 32;
	localparam int unsigned SpaceW = 16;
	localparam int unsigned KindW  = 2;

	// Longest coded form in bytes and the width of a byte count or index.
	localparam int unsigned MaxLen = 5;
	localparam int unsigned LenW   = 3;

	// Lead byte of the five-byte form.
	localparam logic [ByteW-1:0] LeadFive = 8'hF0;

	// Kind of one result beat.
	typedef enum logic [KindW-1:0] {
		KIND_VALUE = 2'd0,
		KIND_BYTE  = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	// What the decoder produces for the byte it is looking at.
	typedef struct packed {
		logic             has_result;
		logic             is_error;
		logic [WordW-1:0] value;
	} dec_res_t;

	// What the encoder produces for the byte index it is at.
	typedef struct packed {
		logic             is_error;
		logic [ByteW-1:0] data;
		logic             last;
	} enc_res_t;

endpackage

>>> src/prefix_varint_codec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prefix_varint_codec: codec for 32-bit integers in 1 to 5 prefix-length bytes
//
// Input channel (in_valid / in_stall): one beat carries a command. cmd = 0
// decodes in_byte (end_of_buffer marks the last byte available); cmd = 1
// encodes word_in into a buffer with space_left free bytes.
// Output channel (out_valid / out_stall): one beat carries one result: a
// decoded value, one encoded byte (most significant first, last on the final
// byte) or an error. Decode and error results always have last set.
// An accepted beat is held in the input register, and its first result is
// loaded into the output register once that register is free to take it.
// Throughput: decode takes one byte per cycle; a byte that completes no number
// gives no result, and one that does waits out an output stall. Encode gives
// its coded bytes (1 to 5) one at a time, paced by the single output register.
// Reset clears both registers' valid flags and the decode and encode state.
// When the receiver stalls, the output beat holds and the input register
// fills; in_stall rises once a beat in it cannot move on.
// ----------------------------------------------------------------------------
module prefix_varint_codec (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        cmd,
	input  logic [pvc_pkg::ByteW-1:0]   in_byte,
	input  logic                        end_of_buffer,
	input  logic [pvc_pkg::WordW-1:0]   word_in,
	input  logic [pvc_pkg::SpaceW-1:0]  space_left,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [pvc_pkg::KindW-1:0]   kind,
	output logic [pvc_pkg::ByteW-1:0]   out_byte,
	output logic [pvc_pkg::WordW-1:0]   out_value,
	output logic                        last
);

	// Input register.
	logic                       valid_s1;
	logic                       cmd_s1;
	logic [pvc_pkg::ByteW-1:0]  in_byte_s1;
	logic                       eob_s1;
	logic [pvc_pkg::WordW-1:0]  word_s1;
	logic [pvc_pkg::SpaceW-1:0] space_s1;

	// Output register.
	logic                       out_valid_q;
	pvc_pkg::kind_t             kind_q;
	logic [pvc_pkg::ByteW-1:0]  byte_q;
	logic [pvc_pkg::WordW-1:0]  value_q;
	logic                       last_q;

	pvc_pkg::dec_res_t dec_res;
	pvc_pkg::enc_res_t enc_res;
	logic              out_load;
	logic              dec_fire;
	logic              enc_fire;
	logic              consume;
	logic              accept;

	pvc_decoder u_dec (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (dec_fire),
		.in_byte       (in_byte_s1),
		.end_of_buffer (eob_s1),
		.res           (dec_res)
	);

	pvc_encoder u_enc (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (enc_fire),
		.word_in    (word_s1),
		.space_left (space_s1),
		.res        (enc_res)
	);

	// Issue control: a decode byte with no result moves on even when the
	// output is stalled; anything that gives a beat needs a free output slot.
	assign out_load = !out_valid_q || !out_stall;
	assign dec_fire = valid_s1 && !cmd_s1 && (!dec_res.has_result || out_load);
	assign enc_fire = valid_s1 && cmd_s1 && out_load;
	assign consume  = dec_fire || (enc_fire && enc_res.last);
	assign in_stall = valid_s1 && !consume;
	assign accept   = in_valid && !in_stall;

	// Input register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1     <= cmd;
			in_byte_s1 <= in_byte;
			eob_s1     <= end_of_buffer;
			word_s1    <= word_in;
			space_s1   <= space_left;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= (dec_fire && dec_res.has_result) || enc_fire;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (out_load) begin
			if (cmd_s1) begin
				kind_q  <= enc_res.is_error ? pvc_pkg::KIND_ERROR : pvc_pkg::KIND_BYTE;
				byte_q  <= enc_res.data;
				value_q <= '0;
				last_q  <= enc_res.last;
			end else begin
				kind_q  <= dec_res.is_error ? pvc_pkg::KIND_ERROR : pvc_pkg::KIND_VALUE;
				byte_q  <= '0;
				value_q <= dec_res.value;
				last_q  <= 1'b1;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign out_byte  = byte_q;
	assign out_value = value_q;
	assign last      = last_q;

endmodule

>>> src/pvc_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvc_decoder: byte-wise decoder of prefix-length varints
// Holds the count of bytes still to come and the partial value. For the byte
// on its input it tells whether a result is due, and it advances its state
// when the top level consumes that byte.
// ----------------------------------------------------------------------------
module pvc_decoder (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       fire,
	input  logic [pvc_pkg::ByteW-1:0]  in_byte,
	input  logic                       end_of_buffer,
	output pvc_pkg::dec_res_t          res
);

	logic [pvc_pkg::LenW-1:0]  pend_q;
	logic [pvc_pkg::LenW-1:0]  pend_d;
	logic [pvc_pkg::WordW-1:0] acc_q;
	logic [pvc_pkg::WordW-1:0] acc_d;
	logic [pvc_pkg::WordW-1:0] acc_shift;
	logic                      need_eob;

	// Next state and result for the current byte.
	always_comb begin
		pend_d    = pend_q;
		acc_d     = acc_q;
		res       = '0;
		need_eob  = 1'b0;
		acc_shift = {acc_q[pvc_pkg::WordW-pvc_pkg::ByteW-1:0], in_byte};
		if (pend_q == '0) begin
			// First byte: the leading ones give the length.
			priority if (!in_byte[7]) begin
				res.has_result = 1'b1;
				res.value      = {{(pvc_pkg::WordW-pvc_pkg::ByteW){1'b0}}, in_byte};
			end else if (!in_byte[6]) begin
				acc_d    = {26'd0, in_byte[5:0]};
				pend_d   = 3'd1;
				need_eob = 1'b1;
			end else if (!in_byte[5]) begin
				acc_d    = {27'd0, in_byte[4:0]};
				pend_d   = 3'd2;
				need_eob = 1'b1;
			end else if (!in_byte[4]) begin
				acc_d    = {28'd0, in_byte[3:0]};
				pend_d   = 3'd3;
				need_eob = 1'b1;
			end else if (!in_byte[3]) begin
				acc_d    = '0;
				pend_d   = 3'd4;
				need_eob = 1'b1;
			end else begin
				res.has_result = 1'b1;
				res.is_error   = 1'b1;
			end
		end else begin
			// Continuation byte: shift it in big-endian.
			pend_d = pend_q - 3'd1;
			if (pend_d == '0) begin
				res.has_result = 1'b1;
				res.value      = acc_shift;
				acc_d          = '0;
			end else begin
				acc_d    = acc_shift;
				need_eob = 1'b1;
			end
		end
		// The buffer ran out in the middle of a number.
		if (need_eob && end_of_buffer) begin
			pend_d         = '0;
			acc_d          = '0;
			res.has_result = 1'b1;
			res.is_error   = 1'b1;
			res.value      = '0;
		end
	end

	// Decode state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			acc_q  <= '0;
		end else if (fire) begin
			pend_q <= pend_d;
			acc_q  <= acc_d;
		end
	end

endmodule

>>> src/pvc_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvc_encoder: shortest-form encoder of prefix-length varints
// Works out the coded length and the coded bytes of a word, left aligned, and
// steps a byte index each time the top level takes one byte.
// ----------------------------------------------------------------------------
module pvc_encoder (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        fire,
	input  logic [pvc_pkg::WordW-1:0]   word_in,
	input  logic [pvc_pkg::SpaceW-1:0]  space_left,
	output pvc_pkg::enc_res_t           res
);

	localparam int unsigned AlignW = pvc_pkg::MaxLen * pvc_pkg::ByteW;

	logic [pvc_pkg::LenW-1:0] idx_q;
	logic [pvc_pkg::LenW-1:0] len;
	logic [AlignW-1:0]        aligned;
	logic                     no_room;

	// Length of the shortest form and its bytes, first byte on top.
	always_comb begin
		priority if (word_in[31:7] == '0) begin
			len     = 3'd1;
			aligned = {word_in[7:0], 32'd0};
		end else if (word_in[31:14] == '0) begin
			len     = 3'd2;
			aligned = {2'b10, word_in[13:0], 24'd0};
		end else if (word_in[31:21] == '0) begin
			len     = 3'd3;
			aligned = {3'b110, word_in[20:0], 16'd0};
		end else if (word_in[31:28] == '0) begin
			len     = 3'd4;
			aligned = {4'b1110, word_in[27:0], 8'd0};
		end else begin
			len     = 3'd5;
			aligned = {pvc_pkg::LeadFive, word_in};
		end
	end

	assign no_room = {{(pvc_pkg::SpaceW-pvc_pkg::LenW){1'b0}}, len} > space_left;

	// Byte at the current index, or one error beat.
	always_comb begin
		res = '0;
		if (no_room) begin
			res.is_error = 1'b1;
			res.last     = 1'b1;
		end else begin
			res.last = (idx_q == len - 3'd1);
			unique case (idx_q)
				3'd0:    res.data = aligned[39:32];
				3'd1:    res.data = aligned[31:24];
				3'd2:    res.data = aligned[23:16];
				3'd3:    res.data = aligned[15:8];
				3'd4:    res.data = aligned[7:0];
				default: res.data = '0;
			endcase
		end
	end

	// Byte index within the current word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (fire) begin
			idx_q <= res.last ? '0 : idx_q + 3'd1;
		end
	end

endmodule

>>> dv/tb_prefix_varint_codec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_prefix_varint_codec: self-checking testbench of the prefix varint codec
// Directed decode and encode beats cover every length class, the boundaries
// between them, bad prefixes, buffers that end inside a number, encode into
// too little space and encode in the middle of a decode. Random traffic then
// mixes well-formed coded numbers with broken ones and noise. A local model
// of the codec predicts every result beat, and each beat taken from the
// output channel is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_prefix_varint_codec;

	// One predicted result beat.
	typedef struct {
		pvc_pkg::kind_t            kind;
		logic [pvc_pkg::ByteW-1:0] data;
		logic [pvc_pkg::WordW-1:0] value;
		logic                      last;
	} codec_result_t;

	logic                         clk;
	logic                         arst_n;
	logic                         in_valid;
	logic                         in_stall;
	logic                         cmd;
	logic [pvc_pkg::ByteW-1:0]    in_byte;
	logic                         end_of_buffer;
	logic [pvc_pkg::WordW-1:0]    word_in;
	logic [pvc_pkg::SpaceW-1:0]   space_left;
	logic                         out_valid;
	logic                         out_stall;
	logic [pvc_pkg::KindW-1:0]    kind;
	logic [pvc_pkg::ByteW-1:0]    out_byte;
	logic [pvc_pkg::WordW-1:0]    out_value;
	logic                         last;

	// Predicted results in order, and the decode state of the local model.
	codec_result_t                expected_results[$];
	logic [pvc_pkg::LenW-1:0]     dec_left;
	logic [pvc_pkg::WordW-1:0]    dec_acc;

	bit                           idle_enable;
	int                           n_beats_in;
	int                           n_values;
	int                           n_bytes;
	int                           n_errors_seen;
	int                           n_fail;

	prefix_varint_codec i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.cmd           (cmd),
		.in_byte       (in_byte),
		.end_of_buffer (end_of_buffer),
		.word_in       (word_in),
		.space_left    (space_left),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.kind          (kind),
		.out_byte      (out_byte),
		.out_value     (out_value),
		.last          (last)
	);

	// 10 ns clock.
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Hard limit on the run time.
	initial begin
		#5_000_000;
		$display("tb_prefix_varint_codec: done, errors");
		$finish;
	end

	// Receiver stalls in random bursts while idling is enabled.
	initial begin
		int n;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (idle_enable && $urandom_range(0, 3) == 0) begin
				n = $urandom_range(1, 11);
				out_stall = 1'b1;
				repeat (n) @(negedge clk);
				out_stall = 1'b0;
			end
		end
	end

	// Largest value that a coded form of the given length can carry.
	function automatic logic [pvc_pkg::WordW-1:0] len_mask(input int len);
		case (len)
			1: len_mask = 32'h0000_007F;
			2: len_mask = 32'h0000_3FFF;
			3: len_mask = 32'h001F_FFFF;
			4: len_mask = 32'h0FFF_FFFF;
			default: len_mask = 32'hFFFF_FFFF;
		endcase
	endfunction

	function automatic void push_result(input pvc_pkg::kind_t k,
			input logic [pvc_pkg::ByteW-1:0] d,
			input logic [pvc_pkg::WordW-1:0] v, input logic l);
		codec_result_t r;
		r.kind  = k;
		r.data  = d;
		r.value = v;
		r.last  = l;
		expected_results.push_back(r);
	endfunction

	// Decode of one coded byte: collects the value and reports it when done.
	function automatic void predict_decode(input logic [pvc_pkg::ByteW-1:0] b,
			input logic eob);
		logic [pvc_pkg::WordW-1:0] v;
		if (dec_left == 0) begin
			if (b[7] == 1'b0) begin
				push_result(pvc_pkg::KIND_VALUE, '0, {24'd0, b}, 1'b1);
				return;
			end else if (b[7:6] == 2'b10) begin
				dec_acc  = {26'd0, b[5:0]};
				dec_left = 3'd1;
			end else if (b[7:5] == 3'b110) begin
				dec_acc  = {27'd0, b[4:0]};
				dec_left = 3'd2;
			end else if (b[7:4] == 4'b1110) begin
				dec_acc  = {28'd0, b[3:0]};
				dec_left = 3'd3;
			end else if (b[7:3] == 5'b11110) begin
				dec_acc  = '0;
				dec_left = 3'd4;
			end else begin
				push_result(pvc_pkg::KIND_ERROR, '0, '0, 1'b1);
				return;
			end
		end else begin
			dec_acc  = {dec_acc[pvc_pkg::WordW-pvc_pkg::ByteW-1:0], b};
			dec_left = dec_left - 3'd1;
			if (dec_left == 0) begin
				v       = dec_acc;
				dec_acc = '0;
				push_result(pvc_pkg::KIND_VALUE, '0, v, 1'b1);
				return;
			end
		end
		// The buffer ran out with bytes of the number still to come.
		if (eob) begin
			dec_left = '0;
			dec_acc  = '0;
			push_result(pvc_pkg::KIND_ERROR, '0, '0, 1'b1);
		end
	endfunction

	// Encode of one value in its shortest form, or an error if it does not fit.
	function automatic void predict_encode(input logic [pvc_pkg::WordW-1:0] w,
			input logic [pvc_pkg::SpaceW-1:0] space);
		int                        len;
		logic [pvc_pkg::WordW-1:0] coded;
		if (w < 32'h80) begin
			len   = 1;
			coded = w;
		end else if (w < 32'h4000) begin
			len   = 2;
			coded = w | 32'h8000;
		end else if (w < 32'h20_0000) begin
			len   = 3;
			coded = w | 32'hC0_0000;
		end else if (w < 32'h1000_0000) begin
			len   = 4;
			coded = w | 32'hE000_0000;
		end else begin
			len   = 5;
			coded = w;
		end
		if (space < len) begin
			push_result(pvc_pkg::KIND_ERROR, '0, '0, 1'b1);
			return;
		end
		if (len == 5) begin
			push_result(pvc_pkg::KIND_BYTE, pvc_pkg::LeadFive, '0, 1'b0);
			len = 4;
		end
		for (int i = len; i > 0; i--)
			push_result(pvc_pkg::KIND_BYTE, coded[8*(i-1) +: 8], '0, i == 1);
	endfunction

	// Drives one beat at the falling edge and holds it until it is accepted.
	task automatic send_beat(input logic c, input logic [pvc_pkg::ByteW-1:0] b,
			input logic eob, input logic [pvc_pkg::WordW-1:0] w,
			input logic [pvc_pkg::SpaceW-1:0] space);
		int gap;
		if (idle_enable && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 11);
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid      = 1'b1;
		cmd           = c;
		in_byte       = b;
		end_of_buffer = eob;
		word_in       = w;
		space_left    = space;
		do @(posedge clk); while (in_stall);
		n_beats_in++;
		if (c == 1'b0)
			predict_decode(b, eob);
		else
			predict_encode(w, space);
	endtask

	// Decode and encode beats carry random data in the fields they ignore.
	task automatic dec_beat(input logic [pvc_pkg::ByteW-1:0] b, input logic eob);
		send_beat(1'b0, b, eob, $urandom, 16'($urandom_range(0, 16'hFFFF)));
	endtask

	task automatic enc_beat(input logic [pvc_pkg::WordW-1:0] w,
			input logic [pvc_pkg::SpaceW-1:0] space);
		send_beat(1'b1, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), w, space);
	endtask

	// Holds the input idle until every predicted result has been taken.
	task automatic wait_drained();
		@(negedge clk);
		in_valid = 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	// Random encode: a value of some length class, mostly with enough space.
	task automatic random_encode();
		int                         len;
		logic [pvc_pkg::WordW-1:0]  w;
		logic [pvc_pkg::SpaceW-1:0] space;
		len = $urandom_range(1, 5);
		w   = $urandom & len_mask(len);
		case ($urandom_range(0, 5))
			0: space = 16'($urandom_range(0, len - 1));
			1: space = 16'($urandom_range(0, 16'hFFFF));
			default: space = 16'($urandom_range(len, 8));
		endcase
		enc_beat(w, space);
	endtask

	// One coded number, optionally cut short by an early end of buffer.
	task automatic send_number(input int len, input bit truncate);
		logic [pvc_pkg::WordW-1:0] w;
		logic [pvc_pkg::WordW-1:0] coded;
		logic [pvc_pkg::ByteW-1:0] seq [5];
		int                        cut;
		logic                      eob;
		w = $urandom & len_mask(len);
		case (len)
			1: coded = w;
			2: coded = w | 32'h8000;
			3: coded = w | 32'hC0_0000;
			4: coded = w | 32'hE000_0000;
			default: coded = w;
		endcase
		if (len == 5) begin
			// The three low bits of the five-byte lead carry nothing.
			seq[0] = pvc_pkg::LeadFive | 8'($urandom_range(0, 7));
			for (int i = 1; i < 5; i++)
				seq[i] = coded[8*(4-i) +: 8];
		end else begin
			for (int i = 0; i < len; i++)
				seq[i] = coded[8*(len-1-i) +: 8];
		end
		cut = (truncate && len > 1) ? $urandom_range(0, len - 2) : len;
		for (int i = 0; i < len && i <= cut; i++) begin
			if (i > 0 && $urandom_range(0, 7) == 0)
				random_encode();
			if (i == cut)
				eob = 1'b1;
			else if (i == len - 1)
				eob = 1'($urandom_range(0, 1));
			else
				eob = 1'b0;
			dec_beat(seq[i], eob);
		end
	endtask

	// Each length class of decode, and an encode in the middle of a number.
	task automatic test_decode_forms();
		dec_beat(8'h00, 1'b1);
		dec_beat(8'h7F, 1'b0);
		dec_beat(8'hBF, 1'b0);
		dec_beat(8'hFF, 1'b1);
		dec_beat(8'hDF, 1'b0);
		dec_beat(8'hFF, 1'b0);
		dec_beat(8'hFF, 1'b0);
		dec_beat(8'hEF, 1'b0);
		enc_beat(32'h0000_3FFF, 16'd2);
		dec_beat(8'hFF, 1'b0);
		dec_beat(8'hFF, 1'b0);
		dec_beat(8'hFF, 1'b0);
		dec_beat(8'hF7, 1'b0);
		repeat (4) dec_beat(8'hFF, 1'b0);
	endtask

	task automatic test_decode_errors();
		dec_beat(8'hF8, 1'b0);
		dec_beat(8'hFF, 1'b1);
		dec_beat(8'h80, 1'b1);
		dec_beat(8'hE0, 1'b0);
		dec_beat(8'h12, 1'b1);
	endtask

	// Boundaries between the encode length classes, and too little space.
	task automatic test_encode_forms();
		enc_beat(32'h0000_0000, 16'd0);
		enc_beat(32'h0000_007F, 16'd1);
		enc_beat(32'h0000_0080, 16'd1);
		enc_beat(32'h0000_4000, 16'd3);
		enc_beat(32'h001F_FFFF, 16'hFFFF);
		enc_beat(32'h0020_0000, 16'd4);
		enc_beat(32'h0FFF_FFFF, 16'd3);
		enc_beat(32'h1000_0000, 16'd5);
		enc_beat(32'hFFFF_FFFF, 16'd4);
		enc_beat(32'hFFFF_FFFF, 16'd5);
	endtask

	// Random traffic: mostly well-formed numbers, then encodes, broken
	// numbers, noise and bad prefixes.
	task automatic test_random_traffic(input int n_items);
		int stop_at;
		stop_at = n_beats_in + n_items;
		while (n_beats_in < stop_at) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: send_number($urandom_range(1, 5), 1'b0);
				5, 6: random_encode();
				7: send_number($urandom_range(2, 5), 1'b1);
				8: dec_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
				default: dec_beat(8'($urandom_range(8'hF8, 8'hFF)),
					1'($urandom_range(0, 1)));
			endcase
		end
	endtask

	// A pause on the input side until the output has caught up.
	task automatic test_drain_pause();
		send_number(5, 1'b0);
		enc_beat(32'hFFFF_FFFF, 16'd5);
		wait_drained();
		send_number(3, 1'b0);
	endtask

	// Checks each output beat against the oldest prediction.
	always @(posedge clk) begin
		codec_result_t r;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result beat: kind %0d byte %h value %h last %b",
					kind, out_byte, out_value, last);
				n_fail++;
			end else begin
				r = expected_results.pop_front();
				case (r.kind)
					pvc_pkg::KIND_VALUE: n_values++;
					pvc_pkg::KIND_BYTE:  n_bytes++;
					default:             n_errors_seen++;
				endcase
				if (kind !== r.kind) begin
					$error("kind: expected %0d, got %0d", r.kind, kind);
					n_fail++;
				end
				if (out_byte !== r.data) begin
					$error("out_byte: expected %h, got %h", r.data, out_byte);
					n_fail++;
				end
				if (out_value !== r.value) begin
					$error("out_value: expected %h, got %h", r.value, out_value);
					n_fail++;
				end
				if (last !== r.last) begin
					$error("last: expected %b, got %b", r.last, last);
					n_fail++;
				end
			end
		end
	end

	// Test sequence.
	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		cmd           = 1'b0;
		in_byte       = '0;
		end_of_buffer = 1'b0;
		word_in       = '0;
		space_left    = '0;
		dec_left      = '0;
		dec_acc       = '0;
		idle_enable   = 1'b1;
		n_beats_in    = 0;
		n_values      = 0;
		n_bytes       = 0;
		n_errors_seen = 0;
		n_fail        = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_decode_forms();
		test_decode_errors();
		test_encode_forms();
		test_random_traffic(130);
		test_drain_pause();
		// Closing stretch runs at full rate on both sides.
		idle_enable = 1'b0;
		test_random_traffic(60);

		wait_drained();
		repeat (10) @(posedge clk);
		$display("Sent %0d input beats; checked %0d decoded values,", n_beats_in, n_values);
		$display("%0d encoded bytes and %0d errors.", n_bytes, n_errors_seen);
		if (n_fail == 0)
			$display("tb_prefix_varint_codec: done, clean");
		else
			$display("tb_prefix_varint_codec: done, errors");
		$finish;
	end

endmodule
